@@ hw/rtl/tsk_pkg.sv @@
`timescale 1ns / 1ps

package tsk_pkg;

    // Sizes of the graph and the edge store.
    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 256;
    localparam int VertW       = $clog2(MaxVertices);
    localparam int CountW      = VertW + 1;
    localparam int EdgeAW      = $clog2(MaxEdges);
    localparam int EdgeCntW    = EdgeAW + 1;
    localparam int DegW        = EdgeAW + 1;

    // Transaction codes of the input channel.
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_SORT  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Word index of the vertex count register.
    localparam logic REG_NUM_VERTICES = 1'b0;
    localparam logic [6:0] NUM_VERTICES_RESET = 7'd64;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] src_vertex;
        logic [5:0] dst_vertex;
        logic       both_ways;
    } t_in_item;

    typedef struct packed {
        logic [5:0] vertex;
        logic       placed;
        logic       last;
        logic       complete;
        logic       edge_dropped;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD2,
        S_CLR,
        S_CNT_RD,
        S_CNT_DEG,
        S_CNT_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP_RD,
        S_POP_NODE,
        S_EMIT,
        S_WALK_RD,
        S_WALK_EDGE,
        S_WALK_DEG,
        S_FINISH
    } t_state;

endpackage

@@ hw/rtl/tsk_ram.sv @@
`timescale 1ns / 1ps

module tsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/tsk_cfg.sv @@
`timescale 1ns / 1ps

module tsk_cfg
    import tsk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output logic [CountW-1:0]   o_active_n
);

    logic [6:0] r_num_vertices;
    logic       w_write;

    assign w_write = psel && penable && pwrite && (paddr[2] == REG_NUM_VERTICES);

    // Vertex count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= NUM_VERTICES_RESET;
        end else if (w_write) begin
            r_num_vertices <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NUM_VERTICES) ? {25'd0, r_num_vertices} : 32'd0;

    // A count above the vertex capacity acts as the capacity.
    assign o_active_n = (r_num_vertices > 7'(MaxVertices)) ? CountW'(MaxVertices)
                                                            : CountW'(r_num_vertices);

endmodule

@@ hw/rtl/topological_sort_kahn_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall o_out_data (t_out_item)
// config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// An add transaction stores one edge, and the reverse edge too when both_ways is set;
// clear empties the edge store. A sort counts degrees and scans for zero-degree
// vertices, then walks the whole single-read-port edge store for each placed vertex.
// Reset is synchronous and active low; it empties the edge store and clears
// the drop flag. A stalled output holds the sort until the result is taken.

module topological_sort_kahn_core
    import tsk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CountW-1:0]   w_n;
    t_state              r_state, n_state;
    logic [EdgeCntW-1:0] r_edge_count, n_edge_count;
    logic                r_drop, n_drop;
    logic [EdgeCntW-1:0] r_idx, n_idx;
    logic [CountW-1:0]   r_head, n_head;
    logic [CountW-1:0]   r_tail, n_tail;
    logic [CountW-1:0]   r_placed_cnt, n_placed_cnt;
    logic [VertW-1:0]    r_node, n_node;
    logic [VertW-1:0]    r_tgt, n_tgt;
    logic                r_pend_valid, n_pend_valid;
    logic [VertW-1:0]    r_pend_vertex, n_pend_vertex;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_data, n_out_data;

    logic                 w_edge_we;
    logic [EdgeAW-1:0]    w_edge_waddr, w_edge_raddr;
    logic [2*VertW-1:0]   w_edge_wdata, w_edge_rdata;
    logic                 w_deg_we;
    logic [VertW-1:0]     w_deg_waddr, w_deg_raddr;
    logic [DegW-1:0]      w_deg_wdata, w_deg_rdata;
    logic                 w_q_we;
    logic [VertW-1:0]     w_q_waddr, w_q_raddr;
    logic [VertW-1:0]     w_q_wdata, w_q_rdata;

    logic                 w_can_load;
    logic [VertW-1:0]     w_e_src, w_e_tgt;
    logic                 w_bad_vertex;
    logic [EdgeCntW:0]    w_need_count;

    tsk_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_active_n (w_n)
    );

    // Edge store: source in the upper half, target in the lower half.
    tsk_ram #(.WIDTH(2*VertW), .DEPTH(MaxEdges)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (w_edge_waddr),
        .i_wdata (w_edge_wdata),
        .i_raddr (w_edge_raddr),
        .o_rdata (w_edge_rdata)
    );

    tsk_ram #(.WIDTH(DegW), .DEPTH(MaxVertices)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (w_deg_we),
        .i_waddr (w_deg_waddr),
        .i_wdata (w_deg_wdata),
        .i_raddr (w_deg_raddr),
        .o_rdata (w_deg_rdata)
    );

    tsk_ram #(.WIDTH(VertW), .DEPTH(MaxVertices)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    assign w_e_src      = w_edge_rdata[2*VertW-1:VertW];
    assign w_e_tgt      = w_edge_rdata[VertW-1:0];
    assign w_can_load   = !r_out_valid || !i_out_stall;
    assign w_bad_vertex = ({1'b0, i_in_data.src_vertex} >= w_n) ||
                          ({1'b0, i_in_data.dst_vertex} >= w_n);
    assign w_need_count = {1'b0, r_edge_count} +
                          (i_in_data.both_ways ? (EdgeCntW+1)'(2) : (EdgeCntW+1)'(1));

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_edge_count <= '0;
            r_drop       <= 1'b0;
            r_idx        <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_placed_cnt <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_edge_count <= n_edge_count;
            r_drop       <= n_drop;
            r_idx        <= n_idx;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_placed_cnt <= n_placed_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_node        <= n_node;
        r_tgt         <= n_tgt;
        r_pend_vertex <= n_pend_vertex;
        r_out_data    <= n_out_data;
    end

    // Sequencer: edge load, degree clear and count, zero-degree scan, then pop and walk.
    always_comb begin
        n_state       = r_state;
        n_edge_count  = r_edge_count;
        n_drop        = r_drop;
        n_idx         = r_idx;
        n_head        = r_head;
        n_tail        = r_tail;
        n_placed_cnt  = r_placed_cnt;
        n_node        = r_node;
        n_tgt         = r_tgt;
        n_pend_valid  = r_pend_valid;
        n_pend_vertex = r_pend_vertex;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_data    = r_out_data;

        w_edge_we    = 1'b0;
        w_edge_waddr = r_edge_count[EdgeAW-1:0];
        w_edge_wdata = {i_in_data.src_vertex, i_in_data.dst_vertex};
        w_edge_raddr = r_idx[EdgeAW-1:0];
        w_deg_we     = 1'b0;
        w_deg_waddr  = r_tgt;
        w_deg_wdata  = '0;
        w_deg_raddr  = w_e_tgt;
        w_q_we       = 1'b0;
        w_q_waddr    = r_tail[VertW-1:0];
        w_q_wdata    = r_tgt;
        w_q_raddr    = r_head[VertW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.mode)
                        MODE_ADD: begin
                            if (w_bad_vertex || (w_need_count > (EdgeCntW+1)'(MaxEdges))) begin
                                n_drop = 1'b1;
                            end else begin
                                w_edge_we    = 1'b1;
                                n_edge_count = r_edge_count + 1'b1;
                                n_node       = i_in_data.dst_vertex;
                                n_tgt        = i_in_data.src_vertex;
                                if (i_in_data.both_ways) begin
                                    n_state = S_ADD2;
                                end
                            end
                        end
                        MODE_SORT: begin
                            n_idx   = '0;
                            n_state = S_CLR;
                        end
                        MODE_CLEAR: begin
                            n_edge_count = '0;
                            n_drop       = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD2: begin
                // Reverse direction of an undirected edge.
                w_edge_we    = 1'b1;
                w_edge_wdata = {r_node, r_tgt};
                n_edge_count = r_edge_count + 1'b1;
                n_state      = S_IDLE;
            end
            S_CLR: begin
                if (r_idx < EdgeCntW'(w_n)) begin
                    w_deg_we    = 1'b1;
                    w_deg_waddr = r_idx[VertW-1:0];
                    n_idx       = r_idx + 1'b1;
                end else begin
                    n_idx   = '0;
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_RD: begin
                if (r_idx < r_edge_count) begin
                    n_state = S_CNT_DEG;
                end else begin
                    n_idx   = '0;
                    n_head  = '0;
                    n_tail  = '0;
                    n_state = S_SCAN_RD;
                end
            end
            S_CNT_DEG: begin
                // Stale edges with an endpoint out of range are skipped.
                if (({1'b0, w_e_src} < w_n) && ({1'b0, w_e_tgt} < w_n)) begin
                    n_tgt   = w_e_tgt;
                    n_state = S_CNT_WR;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_WR: begin
                w_deg_we    = 1'b1;
                w_deg_wdata = w_deg_rdata + 1'b1;
                n_idx       = r_idx + 1'b1;
                n_state     = S_CNT_RD;
            end
            S_SCAN_RD: begin
                w_deg_raddr = r_idx[VertW-1:0];
                if (r_idx < EdgeCntW'(w_n)) begin
                    n_state = S_SCAN_CHK;
                end else begin
                    n_placed_cnt = '0;
                    n_state      = S_POP_RD;
                end
            end
            S_SCAN_CHK: begin
                if (w_deg_rdata == '0) begin
                    w_q_we    = 1'b1;
                    w_q_wdata = r_idx[VertW-1:0];
                    n_tail    = r_tail + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_SCAN_RD;
            end
            S_POP_RD: begin
                if (r_head < r_tail) begin
                    n_head  = r_head + 1'b1;
                    n_state = S_POP_NODE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_POP_NODE: begin
                n_node  = w_q_rdata;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // The previous vertex is known not to be last once another pops.
                if (!r_pend_valid || w_can_load) begin
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '{vertex: r_pend_vertex, placed: 1'b1, last: 1'b0,
                                        complete: 1'b0, edge_dropped: 1'b0};
                    end
                    n_pend_valid  = 1'b1;
                    n_pend_vertex = r_node;
                    n_placed_cnt  = r_placed_cnt + 1'b1;
                    n_idx         = '0;
                    n_state       = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (r_idx < r_edge_count) begin
                    n_state = S_WALK_EDGE;
                end else begin
                    n_state = S_POP_RD;
                end
            end
            S_WALK_EDGE: begin
                if ((w_e_src == r_node) && ({1'b0, w_e_tgt} < w_n)) begin
                    n_tgt   = w_e_tgt;
                    n_state = S_WALK_DEG;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_DEG: begin
                if (w_deg_rdata != '0) begin
                    w_deg_we    = 1'b1;
                    w_deg_wdata = w_deg_rdata - 1'b1;
                    if (w_deg_rdata == DegW'(1)) begin
                        w_q_we = 1'b1;
                        n_tail = r_tail + 1'b1;
                    end
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_WALK_RD;
            end
            S_FINISH: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    if (r_pend_valid) begin
                        n_out_data = '{vertex: r_pend_vertex, placed: 1'b1, last: 1'b1,
                                       complete: (r_placed_cnt == w_n),
                                       edge_dropped: r_drop};
                    end else begin
                        n_out_data = '{vertex: '0, placed: 1'b0, last: 1'b1,
                                       complete: (w_n == '0), edge_dropped: r_drop};
                    end
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The ready queue never gives out more entries than it has taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_head <= r_tail)
        else $error("queue head passed tail");

    // The edge store never counts past its capacity.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_count <= EdgeCntW'(MaxEdges))
        else $error("edge count beyond capacity");

    // A held vertex has always been counted as placed.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_placed_cnt != '0))
        else $error("pending vertex without placed count");

    // A sort run ends with a last-marked transaction.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && w_can_load |=> o_out_valid && o_out_data.last)
        else $error("finished sort without last transaction");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import tsk_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    topological_sort_kahn_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: a copy of the edge store and the vertex count.
    logic [5:0] graph_src[MaxEdges];
    logic [5:0] graph_dst[MaxEdges];
    int         graph_edges;
    bit         graph_dropped;
    int         vert_count_reg;

    t_in_item  pending_items[$];
    t_out_item order_expected[$];
    int        error_count;
    int        accepted_count;
    bit        in_taken;
    bit        driver_pause;
    bit        sender_busy_free;
    bit        recv_busy_free;
    int        recv_hold;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Predict the effect of one accepted transaction.
    function automatic void predict_item(t_in_item it);
        int n;
        int need;
        int deg[MaxVertices];
        int ready[$];
        int node;
        int placed_n;
        t_out_item r;
        n = (vert_count_reg > MaxVertices) ? MaxVertices : vert_count_reg;
        case (it.mode)
            MODE_ADD: begin
                need = it.both_ways ? 2 : 1;
                if (it.src_vertex >= n || it.dst_vertex >= n ||
                    graph_edges + need > MaxEdges) begin
                    graph_dropped = 1'b1;
                end else begin
                    graph_src[graph_edges] = it.src_vertex;
                    graph_dst[graph_edges] = it.dst_vertex;
                    graph_edges++;
                    if (it.both_ways) begin
                        graph_src[graph_edges] = it.dst_vertex;
                        graph_dst[graph_edges] = it.src_vertex;
                        graph_edges++;
                    end
                end
            end
            MODE_SORT: begin
                placed_n = 0;
                for (int v = 0; v < MaxVertices; v++) deg[v] = 0;
                for (int e = 0; e < graph_edges; e++)
                    if (graph_src[e] < n && graph_dst[e] < n) deg[graph_dst[e]]++;
                for (int v = 0; v < n; v++)
                    if (deg[v] == 0) ready.insert(ready.size(), v);
                while (ready.size() > 0) begin
                    node = ready.pop_front();
                    r = '0;
                    r.vertex = node[5:0];
                    r.placed = 1'b1;
                    order_expected.insert(order_expected.size(), r);
                    placed_n++;
                    for (int e = 0; e < graph_edges; e++) begin
                        if (graph_src[e] == node && graph_dst[e] < n &&
                            deg[graph_dst[e]] > 0) begin
                            deg[graph_dst[e]]--;
                            if (deg[graph_dst[e]] == 0)
                                ready.insert(ready.size(), graph_dst[e]);
                        end
                    end
                end
                if (placed_n == 0) begin
                    r = '0;
                    r.last = 1'b1;
                    r.complete = (n == 0);
                    r.edge_dropped = graph_dropped;
                    order_expected.insert(order_expected.size(), r);
                end else begin
                    r = order_expected.pop_back();
                    r.last = 1'b1;
                    r.complete = (placed_n == n);
                    r.edge_dropped = graph_dropped;
                    order_expected.insert(order_expected.size(), r);
                end
            end
            MODE_CLEAR: begin
                graph_edges = 0;
                graph_dropped = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_in_item make_item(logic [1:0] m, int s, int d, bit b);
        t_in_item it;
        it.mode = m;
        it.src_vertex = s[5:0];
        it.dst_vertex = d[5:0];
        it.both_ways = b;
        return it;
    endfunction

    // Driver: offers queued transactions, changing inputs at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_taken) begin
                void'(pending_items.pop_front());
                in_taken = 1'b0;
            end
            if (pending_items.size() > 0 && !driver_pause &&
                (sender_busy_free || $urandom_range(99) >= 27)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_items[0];
            end else begin
                i_in_valid <= 1'b0;
                i_in_data  <= make_item(2'($urandom_range(3)), $urandom_range(63),
                                        $urandom_range(63), 1'($urandom_range(1)));
            end
        end
    end

    // Predict on acceptance, at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_item(i_in_data);
            accepted_count++;
            in_taken = 1'b1;
        end
    end

    // Receiver stall: random, with a long hold-off when requested.
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= recv_busy_free ? 1'b0 : ($urandom_range(99) < 27);
        end
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (order_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, o_out_data);
                error_count++;
            end else begin
                exp_r = order_expected.pop_front();
                if (o_out_data !== exp_r) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, exp_r, o_out_data);
                    error_count++;
                end
            end
        end
    end

    task automatic wait_accepted(int total);
        while (accepted_count < total) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (order_expected.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // APB register write: setup cycle then access cycle.
    task automatic write_vertex_count(int value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {REG_NUM_VERTICES, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        vert_count_reg = value & 32'h7f;
    endtask

    // Queue a clear, a random DAG-ish graph, then a sort.
    task automatic queue_graph(int n, int edges, int cyc_pct);
        int s;
        int d;
        pending_items.insert(pending_items.size(), make_item(MODE_CLEAR, 0, 0, 0));
        for (int k = 0; k < edges; k++) begin
            s = $urandom_range(n > 0 ? n - 1 : 0);
            d = $urandom_range(n > 0 ? n - 1 : 0);
            if ($urandom_range(99) >= cyc_pct && s > d) begin
                s = s ^ d; d = s ^ d; s = s ^ d;
            end
            if ($urandom_range(99) < 8) s = $urandom_range(63);
            pending_items.insert(pending_items.size(),
                                 make_item(MODE_ADD, s, d, $urandom_range(99) < 10));
        end
        pending_items.insert(pending_items.size(), make_item(MODE_SORT, 0, 0, 0));
    endtask

    int issued;

    initial begin
        int nv;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        graph_edges = 0; graph_dropped = 1'b0; vert_count_reg = NUM_VERTICES_RESET;
        error_count = 0; accepted_count = 0; issued = 0; in_taken = 1'b0;
        driver_pause = 1'b0; sender_busy_free = 1'b0; recv_busy_free = 1'b0;
        recv_hold = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty sort at reset size, extremes, self-loop, cycle, unused mode.
        pending_items.insert(pending_items.size(), make_item(MODE_SORT, 0, 0, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 63, 0, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 0, 63, 1));
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 5, 5, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 42, 21, 1));
        pending_items.insert(pending_items.size(), make_item(2'd3, 63, 63, 1));
        pending_items.insert(pending_items.size(), make_item(MODE_SORT, 0, 0, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_CLEAR, 0, 0, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 1, 2, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 2, 3, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_SORT, 0, 0, 0));
        issued += 11;
        wait_accepted(issued);
        wait_drained();

        // Out-of-range endpoints and stale edges after lowering the count.
        write_vertex_count(4);
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 4, 1, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 3, 0, 1));
        pending_items.insert(pending_items.size(), make_item(MODE_SORT, 0, 0, 0));
        issued += 3;
        wait_accepted(issued);
        wait_drained();
        write_vertex_count(0);
        pending_items.insert(pending_items.size(), make_item(MODE_SORT, 0, 0, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 0, 0, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_SORT, 0, 0, 0));
        issued += 3;
        wait_accepted(issued);
        wait_drained();
        write_vertex_count(127);
        pending_items.insert(pending_items.size(), make_item(MODE_CLEAR, 0, 0, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_SORT, 0, 0, 0));
        issued += 2;
        wait_accepted(issued);
        wait_drained();

        // Store full: fill past capacity with both-way edges, then sort.
        for (int k = 0; k < 130; k++)
            pending_items.insert(pending_items.size(),
                                 make_item(MODE_ADD, k % 64, (k + 1) % 64, 1));
        pending_items.insert(pending_items.size(), make_item(MODE_ADD, 1, 3, 0));
        pending_items.insert(pending_items.size(), make_item(MODE_SORT, 0, 0, 0));
        issued += 132;
        // Receiver holds off long while the sender keeps offering.
        recv_hold = 3000;
        wait_accepted(issued);
        wait_drained();

        // Random phases over several vertex counts.
        for (int ph = 0; ph < 10; ph++) begin
            nv = (ph == 0) ? 64 : (ph == 1) ? 1 : $urandom_range(2, 20);
            write_vertex_count(nv);
            sender_busy_free = (ph == 3);
            recv_busy_free = (ph == 3);
            for (int g = 0; g < 3; g++) begin
                queue_graph(nv, $urandom_range(1, 9), 15);
                issued = accepted_count + pending_items.size();
            end
            wait_accepted(issued);
            // Sender pauses until every expected result has arrived.
            driver_pause = 1'b1;
            wait_drained();
            driver_pause = 1'b0;
        end

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog on a generous fixed time.
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
